>>> hw/rtl/hbe_pkg.sv
`timescale 1ns / 1ps
package hbe_pkg;

   localparam int MAX_ATOMS = 1024;
   localparam int ATOM_AW   = $clog2(MAX_ATOMS);
   localparam int CNT_W     = 11;
   localparam int IDX_W     = 10;
   localparam int COORD_W   = 32;
   localparam int MAG_W     = 32;
   localparam int OPD_W     = 33;
   localparam int PROD_W    = 2 * OPD_W;
   localparam int R2_W      = 66;
   localparam int NUM_W     = PROD_W + MAG_W;
   localparam int QUO_W     = 33;
   localparam int DIV_STEPS = QUO_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS);
   localparam int ACC_W     = 50;
   localparam int H_W       = 48;
   localparam int TERMS     = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ATOM_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRING     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF     = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_COINC = 2'd1;
   localparam logic [1:0] STS_RANGE = 2'd2;
   localparam logic [1:0] STS_SAT   = 2'd3;

   typedef enum logic [2:0] {
      MUL_C2, MUL_SQ, MUL_P, MUL_LO, MUL_HI
   } mul_sel_type;

   typedef enum logic [1:0] {
      RES_RANGE, RES_OFF, RES_DIAG
   } res_kind_type;

   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      logic [ATOM_AW-1:0] rd_addr;
      logic               lat_row;
      logic               c2_lat;
      logic               lat_diff;
      mul_sel_type        mul_sel;
      logic [2:0]         idx;
      logic               r2_clr;
      logic               r2_acc;
      logic               p_lat;
      logic               num_lat;
      logic               div_init;
      logic               div_step;
      logic               acc_clr;
      logic               acc_add;
      logic               res_lat;
      res_kind_type       kind;
      logic               coinc;
   } hbe_cmd_type;

   typedef struct packed {
      logic             r2_zero;
      logic             r2_ge_c2;
      logic [CNT_W-1:0] count;
   } hbe_sts_type;

   // axis pairs of the six unique entries: xx yy zz xy xz yz
   function automatic logic [1:0] term_a(input logic [2:0] n);
      case (n)
         3'd0: term_a = 2'd0;
         3'd1: term_a = 2'd1;
         3'd2: term_a = 2'd2;
         3'd3: term_a = 2'd0;
         3'd4: term_a = 2'd0;
         3'd5: term_a = 2'd1;
         default: term_a = 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] term_b(input logic [2:0] n);
      case (n)
         3'd0: term_b = 2'd0;
         3'd1: term_b = 2'd1;
         3'd2: term_b = 2'd2;
         3'd3: term_b = 2'd1;
         3'd4: term_b = 2'd2;
         3'd5: term_b = 2'd2;
         default: term_b = 2'd0;
      endcase
   endfunction

endpackage

>>> hw/rtl/hbe_ctrl.sv
`timescale 1ns / 1ps
module hbe_ctrl import hbe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             opcode,
   input  logic [IDX_W-1:0] row_index,
   input  logic [IDX_W-1:0] col_index,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  hbe_sts_type      sts,
   output hbe_cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_RDROW, S_LATROW, S_C2LAT, S_PAIR, S_DIFF,
      S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_CMP,
      S_TP, S_TLO, S_THI, S_TSUM, S_TDIV, S_TACC, S_NEXT, S_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [2:0]         n_ff, n_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;
   logic               diag_ff, diag_in;
   logic               coinc_ff, coinc_in;
   res_kind_type       kind_ff, kind_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               in_range;
   logic               rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign in_range   = ({1'b0, row_index} < sts.count) && ({1'b0, col_index} < sts.count);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      row_in       = row_ff;
      n_in         = n_ff;
      dcnt_in      = dcnt_ff;
      diag_in      = diag_ff;
      coinc_in     = coinc_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.mul_sel  = MUL_C2;
      cmd.kind     = kind_ff;
      cmd.coinc    = coinc_ff;
      cmd.idx      = n_ff;
      cmd.rd_addr  = j_ff[ATOM_AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (opcode == OP_LOAD) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.acc_clr = 1'b1;
                  coinc_in    = 1'b0;
                  row_in      = row_index;
                  diag_in     = (row_index == col_index);
                  j_in        = (row_index == col_index) ? '0 : {1'b0, col_index};
                  if (!in_range) begin
                     kind_in  = RES_RANGE;
                     state_in = S_FIN;
                  end else begin
                     kind_in  = (row_index == col_index) ? RES_DIAG : RES_OFF;
                     state_in = S_RDROW;
                  end
               end
            end
         end
         S_RDROW: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = row_ff[ATOM_AW-1:0];
            state_in    = S_LATROW;
         end
         S_LATROW: begin
            cmd.lat_row = 1'b1;
            cmd.mul_sel = MUL_C2;
            state_in    = S_C2LAT;
         end
         S_C2LAT: begin
            cmd.c2_lat = 1'b1;
            state_in   = S_PAIR;
         end
         S_PAIR: begin
            if (diag_ff && j_ff == sts.count) begin
               state_in = S_FIN;
            end else if (diag_ff && j_ff == {1'b0, row_ff}) begin
               j_in = j_ff + 1'b1;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.lat_diff = 1'b1;
            state_in     = S_SQ0;
         end
         S_SQ0: begin
            cmd.mul_sel = MUL_SQ;
            cmd.idx     = 3'd0;
            cmd.r2_clr  = 1'b1;
            state_in    = S_SQ1;
         end
         S_SQ1: begin
            cmd.mul_sel = MUL_SQ;
            cmd.idx     = 3'd1;
            cmd.r2_acc  = 1'b1;
            state_in    = S_SQ2;
         end
         S_SQ2: begin
            cmd.mul_sel = MUL_SQ;
            cmd.idx     = 3'd2;
            cmd.r2_acc  = 1'b1;
            state_in    = S_SQ3;
         end
         S_SQ3: begin
            cmd.r2_acc = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            n_in = '0;
            if (sts.r2_zero) begin
               coinc_in = 1'b1;
               state_in = S_NEXT;
            end else if (sts.r2_ge_c2) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_TP;
            end
         end
         S_TP: begin
            cmd.mul_sel = MUL_P;
            state_in    = S_TLO;
         end
         S_TLO: begin
            cmd.mul_sel = MUL_LO;
            cmd.p_lat   = 1'b1;
            state_in    = S_THI;
         end
         S_THI: begin
            cmd.mul_sel = MUL_HI;
            cmd.num_lat = 1'b1;
            state_in    = S_TSUM;
         end
         S_TSUM: begin
            cmd.div_init = 1'b1;
            dcnt_in      = '0;
            state_in     = S_TDIV;
         end
         S_TDIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = S_TACC;
            end
         end
         S_TACC: begin
            cmd.acc_add = 1'b1;
            if (n_ff == 3'(TERMS - 1)) begin
               state_in = S_NEXT;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_TP;
            end
         end
         S_NEXT: begin
            if (diag_ff) begin
               j_in     = j_ff + 1'b1;
               state_in = S_PAIR;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               cmd.res_lat  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         row_ff       <= '0;
         n_ff         <= '0;
         dcnt_ff      <= '0;
         diag_ff      <= 1'b0;
         coinc_ff     <= 1'b0;
         kind_ff      <= RES_RANGE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         row_ff       <= row_in;
         n_ff         <= n_in;
         dcnt_ff      <= dcnt_in;
         diag_ff      <= diag_in;
         coinc_ff     <= coinc_in;
         kind_ff      <= kind_in;
      end
   end

endmodule

>>> hw/rtl/hbe_datapath.sv
`timescale 1ns / 1ps
module hbe_datapath import hbe_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  hbe_cmd_type             cmd,
   output hbe_sts_type             sts,
   input  logic [IDX_W-1:0]        row_index,
   input  logic [COORD_W-1:0]      coord_x,
   input  logic [COORD_W-1:0]      coord_y,
   input  logic [COORD_W-1:0]      coord_z,
   input  logic                    csr_wr,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_data,
   output logic [TERMS*H_W-1:0]    rsp_data,
   output logic [1:0]              rsp_status
);

   logic [3*COORD_W-1:0] coord_mem [MAX_ATOMS];
   logic [3*COORD_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]  atom_count_ff;
   logic [CSR_W-1:0]  spring_ff;
   logic [CSR_W-1:0]  cutoff_ff;

   logic [COORD_W-1:0] row_ff [3];
   logic [MAG_W-1:0]   mag_ff [3];
   logic [2:0]         neg_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  c2_ff;
   logic [R2_W-1:0]    r2_ff;
   logic [MAG_W-1:0]   p_hi_ff;
   logic [PROD_W-1:0]  num_lo_ff;
   logic [R2_W-1:0]    rem_ff;
   logic [QUO_W-1:0]   dlo_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic signed [ACC_W-1:0] acc_ff [TERMS];
   logic [H_W-1:0]     h_ff [TERMS];
   logic [1:0]         status_ff;

   logic [OPD_W-1:0]   op_a, op_b, two_k;
   logic [1:0]         ax_a, ax_b;
   logic [NUM_W-1:0]   num;
   logic [R2_W:0]      trial;
   logic               trial_ge;
   logic signed [QUO_W:0] term;
   logic signed [ACC_W:0] res_v [TERMS];
   logic [TERMS-1:0]   clamp_hi, clamp_lo;

   assign two_k = {spring_ff, 1'b0};
   assign ax_a  = term_a(cmd.idx);
   assign ax_b  = term_b(cmd.idx);

   always_comb begin
      case (cmd.mul_sel)
         MUL_C2: begin
            op_a = {1'b0, cutoff_ff};
            op_b = {1'b0, cutoff_ff};
         end
         MUL_SQ: begin
            op_a = {1'b0, mag_ff[cmd.idx[1:0]]};
            op_b = {1'b0, mag_ff[cmd.idx[1:0]]};
         end
         MUL_P: begin
            op_a = {1'b0, mag_ff[ax_a]};
            op_b = {1'b0, mag_ff[ax_b]};
         end
         MUL_LO: begin
            op_a = two_k;
            op_b = {1'b0, prod_ff[MAG_W-1:0]};
         end
         MUL_HI: begin
            op_a = two_k;
            op_b = {1'b0, p_hi_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // numerator 2k*|da*db|, assembled from the two partial products
   assign num      = {prod_ff, {MAG_W{1'b0}}} + NUM_W'(num_lo_ff);
   assign trial    = {rem_ff, dlo_ff[QUO_W-1]};
   assign trial_ge = trial >= {1'b0, r2_ff};
   assign term     = (neg_ff[ax_a] == neg_ff[ax_b]) ? -$signed({1'b0, quo_ff})
                                                    :  $signed({1'b0, quo_ff});

   assign sts.r2_zero  = (r2_ff == '0);
   assign sts.r2_ge_c2 = (r2_ff >= R2_W'(c2_ff));
   assign sts.count    = (atom_count_ff > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS)
                                                             : atom_count_ff;

   always_comb begin
      for (int n = 0; n < TERMS; n++) begin
         res_v[n]    = (cmd.kind == RES_DIAG) ? -(ACC_W+1)'(acc_ff[n])
                                              :  (ACC_W+1)'(acc_ff[n]);
         clamp_hi[n] = res_v[n] > (ACC_W+1)'(signed'({1'b0, {(H_W-1){1'b1}}}));
         clamp_lo[n] = res_v[n] < -(ACC_W+1)'(signed'({1'b0, 1'b1, {(H_W-1){1'b0}}}));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && ({1'b0, row_index} < CNT_W'(MAX_ATOMS))) begin
         coord_mem[row_index[ATOM_AW-1:0]] <= {coord_z, coord_y, coord_x};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= coord_mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         atom_count_ff <= '0;
         spring_ff     <= 32'd65536;
         cutoff_ff     <= 32'd983040;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_ATOM_COUNT: atom_count_ff <= csr_data[CNT_W-1:0];
            CSR_SPRING:     spring_ff     <= csr_data;
            CSR_CUTOFF:     cutoff_ff     <= csr_data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      logic signed [COORD_W:0] d;
      prod_ff <= op_a * op_b;
      if (cmd.lat_row) begin
         for (int n = 0; n < 3; n++) begin
            row_ff[n] <= rd_data_ff[n*COORD_W +: COORD_W];
         end
      end
      if (cmd.c2_lat) begin
         c2_ff <= prod_ff;
      end
      if (cmd.lat_diff) begin
         for (int n = 0; n < 3; n++) begin
            d = $signed({row_ff[n][COORD_W-1], row_ff[n]})
              - $signed({rd_data_ff[n*COORD_W+COORD_W-1], rd_data_ff[n*COORD_W +: COORD_W]});
            neg_ff[n] <= d[COORD_W];
            mag_ff[n] <= d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
         end
      end
      if (cmd.r2_clr) begin
         r2_ff <= '0;
      end else if (cmd.r2_acc) begin
         r2_ff <= r2_ff + R2_W'(prod_ff);
      end
      if (cmd.p_lat) begin
         p_hi_ff <= prod_ff[2*MAG_W-1:MAG_W];
      end
      if (cmd.num_lat) begin
         num_lo_ff <= prod_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= R2_W'(num[NUM_W-1:QUO_W]);
         dlo_ff <= num[QUO_W-1:0];
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? R2_W'(trial - {1'b0, r2_ff}) : trial[R2_W-1:0];
         dlo_ff <= {dlo_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], trial_ge};
      end
      for (int n = 0; n < TERMS; n++) begin
         if (cmd.acc_clr) begin
            acc_ff[n] <= '0;
         end else if (cmd.acc_add && cmd.idx == 3'(n)) begin
            acc_ff[n] <= acc_ff[n] + ACC_W'(term);
         end
      end
      if (cmd.res_lat) begin
         for (int n = 0; n < TERMS; n++) begin
            if (clamp_hi[n]) begin
               h_ff[n] <= {1'b0, {(H_W-1){1'b1}}};
            end else if (clamp_lo[n]) begin
               h_ff[n] <= {1'b1, {(H_W-1){1'b0}}};
            end else begin
               h_ff[n] <= res_v[n][H_W-1:0];
            end
         end
         case (cmd.kind)
            RES_RANGE: status_ff <= STS_RANGE;
            RES_DIAG:  status_ff <= (|(clamp_hi | clamp_lo)) ? STS_SAT
                                  : (cmd.coinc ? STS_COINC : STS_OK);
            default:   status_ff <= cmd.coinc ? STS_COINC : STS_OK;
         endcase
      end
   end

   always_comb begin
      for (int n = 0; n < TERMS; n++) begin
         rsp_data[n*H_W +: H_W] = h_ff[n];
      end
   end
   assign rsp_status = status_ff;

endmodule

>>> hw/rtl/anm_hessian_block_engine.sv
`timescale 1ns / 1ps
// channel  direction  signals                                  content
// req      in         req_tvalid/tready, req_tdata, req_tuser  load atom or block query
// rsp      out        rsp_tvalid/tready, rsp_tdata, rsp_tuser  six block entries, status
// csr      in         csr_valid/ready, csr_index, csr_data     atom_count, k, cutoff
//
// A load is stored as taken; an out-of-range query goes straight to a result.
// A pair inside the cutoff computes all six entries; a far or coincident pair
// skips them. A diagonal query does this for every other atom in use.
// Per pair: 3 squares on the one shared 33x33 multiplier for r^2, then per
// entry 3 multiplies and a 33-step radix-2 divide.
// Reset is synchronous; the coordinate store has no clearing pass.
// A finished result waits in the output register; loads and a new query are
// taken meanwhile, and a query holds at its end until the register is free.
module anm_hessian_block_engine import hbe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [9:0] row_index, [19:10] col_index, [51:20] coord_x, [83:52] coord_y,
   // [115:84] coord_z, [119:116] zero
   input  logic [119:0]          req_tdata,
   // [0] opcode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [47:0] h_xx, [95:48] h_yy, [143:96] h_zz, [191:144] h_xy,
   // [239:192] h_xz, [287:240] h_yz
   output logic [TERMS*H_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_data
);

   hbe_cmd_type cmd;
   hbe_sts_type sts;

   assign csr_ready = 1'b1;

   hbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser),
      .row_index  (req_tdata[9:0]),
      .col_index  (req_tdata[19:10]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hbe_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .row_index  (req_tdata[9:0]),
      .coord_x    (req_tdata[51:20]),
      .coord_y    (req_tdata[83:52]),
      .coord_z    (req_tdata[115:84]),
      .csr_wr     (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

>>> hw/rtl/hbe_checker.sv
`timescale 1ns / 1ps
module hbe_checker import hbe_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [TERMS*H_W-1:0]  rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   a_rst_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // no transaction yields a result in the cycle after it is taken
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STS_RANGE |-> rsp_tdata == '0)
      else $error("out-of-range block not zero");

endmodule

bind anm_hessian_block_engine hbe_checker u_hbe_checker (.*);
